// File: rtl/lattice_wave_cycle_length_macros.svh
// Assertion shorthands used by the top-level RTL module.
`ifndef LATTICE_WAVE_CYCLE_LENGTH_MACROS_SVH
`define LATTICE_WAVE_CYCLE_LENGTH_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LWCL_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// Next-cycle implication, checked on every rising edge outside reset.
`define LWCL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

// File: rtl/lwcl_pkg.sv
package lwcl_pkg;

  localparam int STATE_W          = 54;
  localparam int LEN_W            = 20;
  localparam int POW_W            = LEN_W + 1;
  localparam int LATTICE_SIZE_DEF = 3;
  localparam logic [LEN_W-1:0] MAX_STEPS_RESET = LEN_W'(100000);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } ctrl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture start state, hare = one step ahead
    logic iter;    // one search step
    logic finish;  // write result into output register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic done;      // tortoise == hare, or step limit reached
    logic out_full;  // output register holds a result not taken this cycle
  } dp_stat_t;

endpackage

// File: rtl/lattice_wave_cycle_length.sv
// channel   | dir | tdata                       | tuser     | note
// s_axis    | in  | [53:0] start_state          | -         | one start state per item
// m_axis    | out | [19:0] cycle_length         | [0] found | one result per item
// cfg       | in  | cfg_wdata = max_steps       | -         | write on cfg_we, no read-back
//
// Sequence: a load, then one hare step per cycle, then a write of the
//   result. With period p and tail t the search runs for fewer than
//   2*max(p, t+1)+p steps, and it stops when the step counter reaches
//   max_steps. The running search loop takes one lattice step per clock.
// Reset: rst, synchronous; clears control and sets max_steps to 100000.
// Stalls: a finished result sits in the output register while the next item
//   is accepted; a search waits only if that register is still full at its end.
module lattice_wave_cycle_length #(
  parameter int LATTICE_SIZE = lwcl_pkg::LATTICE_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // config: max_steps
  input  logic        cfg_we,
  input  logic [19:0] cfg_wdata,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // [53:0] start_state, [55:54] zero pad
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [19:0] cycle_length, [23:20] zero pad
  output logic        m_axis_tuser    // [0] found
);
  import lwcl_pkg::*;

`include "lattice_wave_cycle_length_macros.svh"

  dp_cmd_t          cmd;
  dp_stat_t         stat;
  logic [LEN_W-1:0] out_len;
  logic             out_found;
  logic             lam_le_pow;

  lwcl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lwcl_dp #(
    .LATTICE_SIZE (LATTICE_SIZE)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_state   (s_axis_tdata[STATE_W-1:0]),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_len    (out_len),
    .out_found  (out_found),
    .lam_le_pow (lam_le_pow)
  );

  assign m_axis_tdata = {4'b0, out_len};
  assign m_axis_tuser = out_found;

  // a found period is never zero; not found always reports zero
  `LWCL_ASSERT_SAME(a_found_nonzero, clk, rst, m_axis_tvalid && m_axis_tuser, out_len != '0)
  `LWCL_ASSERT_SAME(a_miss_zero, clk, rst, m_axis_tvalid && !m_axis_tuser, out_len == '0)
  // taking an item starts a search, so input closes next cycle
  `LWCL_ASSERT_NEXT(a_busy_after_load, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // Brent phase counter never passes the current power while stepping
  `LWCL_ASSERT_SAME(a_lam_bound, clk, rst, cmd.iter, lam_le_pow)

endmodule

// File: rtl/lwcl_ctrl.sv
module lwcl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  lwcl_pkg::dp_stat_t stat,
  output lwcl_pkg::dp_cmd_t  cmd
);
  import lwcl_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!stat.done) begin
          cmd.iter = 1'b1;
        end else if (!stat.out_full) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/lwcl_dp.sv
module lwcl_dp #(
  parameter int LATTICE_SIZE = lwcl_pkg::LATTICE_SIZE_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [lwcl_pkg::STATE_W-1:0] in_state,
  input  logic                        cfg_we,
  input  logic [lwcl_pkg::LEN_W-1:0]   cfg_wdata,
  input  lwcl_pkg::dp_cmd_t            cmd,
  output lwcl_pkg::dp_stat_t           stat,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lwcl_pkg::LEN_W-1:0]   out_len,
  output logic                        out_found,
  output logic                        lam_le_pow
);
  import lwcl_pkg::*;

  localparam int L = LATTICE_SIZE;

  // One lattice step: next = parity(six neighbors' current) ^ previous,
  // old current moves to previous. Bits past the last site come out zero.
  function automatic logic [STATE_W-1:0] lat_step(input logic [STATE_W-1:0] s);
    logic [STATE_W-1:0] n;
    int xp, xm, yp, ym, zp, zm, i;
    logic par;
    n = '0;
    for (int z = 0; z < L; z++) begin
      for (int y = 0; y < L; y++) begin
        for (int x = 0; x < L; x++) begin
          xp  = (x == L - 1) ? 0 : x + 1;
          xm  = (x == 0) ? L - 1 : x - 1;
          yp  = (y == L - 1) ? 0 : y + 1;
          ym  = (y == 0) ? L - 1 : y - 1;
          zp  = (z == L - 1) ? 0 : z + 1;
          zm  = (z == 0) ? L - 1 : z - 1;
          i   = x + L * y + L * L * z;
          par = s[2 * (xp + L * y + L * L * z)] ^ s[2 * (xm + L * y + L * L * z)]
              ^ s[2 * (x + L * yp + L * L * z)] ^ s[2 * (x + L * ym + L * L * z)]
              ^ s[2 * (x + L * y + L * L * zp)] ^ s[2 * (x + L * y + L * L * zm)];
          n[2 * i]     = par ^ s[2 * i + 1];
          n[2 * i + 1] = s[2 * i];
        end
      end
    end
    return n;
  endfunction

  logic [STATE_W-1:0] tortoise, hare;
  logic [POW_W-1:0]   power;
  logic [LEN_W-1:0]   lam;
  logic [LEN_W-1:0]   max_steps;
  logic               lam_lt;
  logic               hit_pow;
  logic [LEN_W-1:0]   lam_base;

  assign lam_lt     = lam < max_steps;
  assign hit_pow    = power == {1'b0, lam};
  assign lam_base   = hit_pow ? '0 : lam;
  assign lam_le_pow = {1'b0, lam} <= power;

  assign stat.done     = (tortoise == hare) || !lam_lt;
  assign stat.out_full = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_steps <= MAX_STEPS_RESET;
    end else if (cfg_we) begin
      max_steps <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tortoise <= in_state;
      hare     <= lat_step(in_state);
      power    <= POW_W'(1);
      lam      <= LEN_W'(1);
    end else if (cmd.iter) begin
      if (hit_pow) begin
        tortoise <= hare;
        power    <= {power[POW_W-2:0], 1'b0};
      end
      hare <= lat_step(hare);
      lam  <= lam_base + LEN_W'(1);
    end
  end

  // output register, free again once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_len   <= lam_lt ? lam : '0;
      out_found <= lam_lt;
    end
  end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import lwcl_pkg::*;

  // Lattice edge length used by the block (default parameter).
  localparam int L = LATTICE_SIZE_DEF;

  // Settle time after the last result before a register write or the end.
  // Every item yields exactly one result, so this is only a safety margin.
  localparam int SETTLE_CYCLES = 16;

  // Orbits of this automaton are very short: the state update is linear over
  // GF(2) and its order divides 6 on the 3x3x3 torus. The watchdog limit
  // covers the longest sender gap, the longest receiver stall, the block's own
  // search and the pause between phases, many times over.
  localparam int WATCHDOG_LIMIT = 4000;

  typedef logic [STATE_W-1:0] lattice_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             found;
  } period_t;

  // Predicts the period search for each accepted start state and checks the
  // results in order.
  class period_book;
    period_t          expected_periods[$];
    logic [LEN_W-1:0] limit;
    int               errors;

    function new();
      limit  = MAX_STEPS_RESET;
      errors = 0;
    endfunction

    function int site(int x, int y, int z);
      return x + L * y + L * L * z;
    endfunction

    // One lattice step: next = parity of six neighbors' current bits ^ previous.
    function lattice_t wave_step(lattice_t s);
      lattice_t nx;
      int       x, y, z, i;
      logic     par;
      nx = '0;
      for (z = 0; z < L; z++) begin
        for (y = 0; y < L; y++) begin
          for (x = 0; x < L; x++) begin
            i   = site(x, y, z);
            par = s[2 * site((x + 1) % L, y, z)] ^ s[2 * site((x + L - 1) % L, y, z)]
                ^ s[2 * site(x, (y + 1) % L, z)] ^ s[2 * site(x, (y + L - 1) % L, z)]
                ^ s[2 * site(x, y, (z + 1) % L)] ^ s[2 * site(x, y, (z + L - 1) % L)];
            nx[2 * i]     = par ^ s[2 * i + 1];
            nx[2 * i + 1] = s[2 * i];
          end
        end
      end
      return nx;
    endfunction

    // Brent search; counter at or past the limit means not found.
    function period_t brent_period(lattice_t start);
      lattice_t    tort, hare;
      int unsigned power, lam;
      period_t     p;
      tort  = start;
      hare  = wave_step(tort);
      power = 1;
      lam   = 1;
      while (tort != hare && lam < limit) begin
        if (power == lam) begin
          tort  = hare;
          power = power << 1;
          lam   = 0;
        end
        hare = wave_step(hare);
        lam++;
      end
      if (lam >= limit) begin
        p.len   = '0;
        p.found = 1'b0;
      end else begin
        p.len   = lam[LEN_W-1:0];
        p.found = 1'b1;
      end
      return p;
    endfunction

    function void note_start(lattice_t s);
      expected_periods.push_back(brent_period(s));
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    task check_period(logic [LEN_W-1:0] len, logic found);
      period_t e;
      if (expected_periods.size() == 0) begin
        report($sformatf("unexpected result len=%0d found=%0b", len, found));
        return;
      end
      e = expected_periods.pop_front();
      if (len !== e.len)
        report($sformatf("cycle_length got %0d want %0d", len, e.len));
      if (found !== e.found)
        report($sformatf("found got %0b want %0b", found, e.found));
    endtask
  endclass

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [19:0]      cfg_wdata;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [55:0]      s_axis_tdata;   // [53:0] start_state, [55:54] zero
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [23:0]      m_axis_tdata;   // [19:0] cycle_length, [23:20] zero
  logic             m_axis_tuser;   // [0] found

  period_book book;
  bit         busy_mode;   // phase with no idling on either side
  int         idle_cycles;

  lattice_wave_cycle_length DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Gap length for either side: mostly none or short, now and then long.
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (busy_mode) return 0;
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Start-state mix: dense random, sparse one/two-bit seeds, and states with
  // only current or only previous bits set.
  function lattice_t rand_lattice();
    int       r;
    lattice_t s;
    r = $urandom_range(0, 9);
    s = lattice_t'({$urandom, $urandom});
    if (r >= 6 && r <= 7) begin
      s = lattice_t'(1) << $urandom_range(0, STATE_W - 1);
      if (r == 7) s = s | (lattice_t'(1) << $urandom_range(0, STATE_W - 1));
    end else if (r == 8) begin
      s = s & 54'h15555555555555;   // current bits only
    end else if (r == 9) begin
      s = s & 54'h2AAAAAAAAAAAAA;   // previous bits only
    end
    return s;
  endfunction

  // Present one start state; tvalid stays high across back-to-back items.
  task send_state(lattice_t s);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, s};
    do @(posedge clk); while (!s_axis_tready);
    book.note_start(s);
  endtask

  // Drop tvalid, wait until every result is back, then let the block settle.
  task drain();
    s_axis_tvalid <= 1'b0;
    while (book.expected_periods.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write only while idle; predictor follows at the same edge.
  task write_limit(logic [19:0] v);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(posedge clk);
    book.limit = v;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task random_phase(logic [19:0] lim, int n);
    busy_mode = ($urandom_range(0, 3) == 0);
    write_limit(lim);
    repeat (n) send_state(rand_lattice());
    drain();
  endtask

  // Result side: check every accepted result, stall tready at random.
  initial begin
    int  hold;
    logic rdy;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready)
        book.check_period(m_axis_tdata[19:0], m_axis_tuser);
      if (hold > 0) begin
        hold--;
      end else begin
        if (busy_mode || $urandom_range(0, 99) < 60) begin
          rdy  = 1'b1;
          hold = busy_mode ? 0 : $urandom_range(0, 8);
        end else begin
          rdy  = 1'b0;
          hold = pick_gap();
        end
        m_axis_tready <= rdy;
      end
    end
  end

  // Watchdog: cycles in a row with no item moving on either side.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    lattice_t corner_cases[$];
    book      = new();
    busy_mode = 1'b0;

    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    m_axis_tready <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, reset limit: quiescent lattice (fixed point, period 1), all
    // ones, lone bits at both ends of the word, current-only and
    // previous-only patterns, and a few mixed words.
    corner_cases = '{54'h0, 54'h3FFFFFFFFFFFFF, 54'h1, 54'h2,
                     54'h10000000000000, 54'h20000000000000,
                     54'h15555555555555, 54'h2AAAAAAAAAAAAA,
                     54'h0F0F0F0F0F0F0F, 54'h30F0F0F0F0F0F0,
                     54'h123456789ABCDE, 54'h000000FFFFFFFF};
    foreach (corner_cases[k]) send_state(corner_cases[k]);
    drain();

    // Limit of zero: every search gives up at once.
    write_limit(20'd0);
    send_state(54'h0);
    send_state(54'h3FFFFFFFFFFFFF);
    drain();

    // Limit of one: not found even though the quiescent lattice matches on
    // the first comparison.
    write_limit(20'd1);
    send_state(54'h0);
    send_state(54'h1);
    drain();

    // Random phases across a spread of limits, extremes included; small
    // limits cut the search at every checkpoint boundary.
    random_phase(20'hFFFFF, 40);
    random_phase(20'd1, 40);
    random_phase(20'd2, 40);
    random_phase(20'd3, 40);
    random_phase(20'd4, 40);
    random_phase(20'd5, 40);
    random_phase(20'd8, 40);
    random_phase(20'($urandom_range(1, 20)), 40);
    random_phase(20'($urandom_range(1, 1048575)), 40);
    random_phase(MAX_STEPS_RESET, 40);

    if (book.errors == 0 && book.expected_periods.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/lwcl_pkg.sv
rtl/lwcl_ctrl.sv
rtl/lwcl_dp.sv
rtl/lattice_wave_cycle_length.sv
dv/tb_top.sv
